// ----- sv/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and constants shared by the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int EPS_WIDTH = 15;
  localparam int EPS_RESET = 1;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  localparam logic ST_OK = 1'b0;
  localparam logic ST_ARG_ERR = 1'b1;
endpackage

// ----- sv/rmq_sqrt.sv -----
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per stage, with a sideband
// word carried alongside.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int AW = 32,
  parameter int SBW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [AW-1:0]       in_arg,
  input  logic [SBW-1:0]      in_sb,
  output logic                out_valid,
  output logic [AW/2-1:0]     out_root,
  output logic [SBW-1:0]      out_sb
);
  localparam int RW = AW / 2;

  logic [AW-1:0]  rem_r [RW+1];
  logic [RW-1:0]  root_r [RW+1];
  logic [SBW-1:0] sb_r [RW+1];
  logic           vld_r [RW+1];

  always_comb begin
    rem_r[0] = in_arg;
    root_r[0] = '0;
    sb_r[0] = in_sb;
    vld_r[0] = in_valid;
  end

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [AW+1:0] trial;
    logic [AW-1:0] rem_nxt;
    logic [RW-1:0] root_nxt;
    always_comb begin
      trial = {2'b00, rem_r[k]}
        - (({{(AW+2-RW){1'b0}}, root_r[k]} << (B + 1)) | ((AW+2)'(1) << (2 * B)));
      if (!trial[AW+1]) begin
        rem_nxt = trial[AW-1:0];
        root_nxt = root_r[k] | (RW'(1) << B);
      end else begin
        rem_nxt = rem_r[k];
        root_nxt = root_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (en) begin
        rem_r[k+1] <= rem_nxt;
        root_r[k+1] <= root_nxt;
        sb_r[k+1] <= sb_r[k];
      end
    end
  end

  assign out_valid = vld_r[RW];
  assign out_root = root_r[RW];
  assign out_sb = sb_r[RW];
endmodule

// ----- sv/rmq_div_lane.sv -----
// ----------------------------------------------------------------------------
// rmq_div_lane
// One division lane: signed numerator over positive divisor, rounded to
// nearest with ties away from zero and saturated, one quotient bit a stage.
// ----------------------------------------------------------------------------
module rmq_div_lane #(
  parameter int NW = 17,
  parameter int DW = 16,
  parameter int QW = 32,
  parameter int FRAC_BITS = 14,
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [NW-1:0]         num,
  input  logic [DW-1:0]                den,
  output logic signed [DATA_WIDTH-1:0] quo
);
  localparam int XW = QW + DW + 1;

  logic [XW-1:0] rem_r [QW+1];
  logic [QW-1:0] dvd_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic          neg_r [QW+1];

  logic [NW-1:0] mag;
  logic [QW-1:0] dvd0;
  always_comb begin
    mag = num[NW-1] ? NW'(-num) : NW'(num);
    dvd0 = (QW'(mag) << FRAC_BITS) + QW'(den >> 1);
    rem_r[0] = '0;
    dvd_r[0] = dvd0;
    q_r[0] = '0;
    den_r[0] = den;
    neg_r[0] = num[NW-1];
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [XW-1:0] sh;
    logic [XW-1:0] diff;
    always_comb begin
      sh = {rem_r[k][XW-2:0], dvd_r[k][QW-1]};
      diff = sh - XW'(den_r[k]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (sh >= XW'(den_r[k])) begin
          rem_r[k+1] <= diff;
          q_r[k+1] <= {q_r[k][QW-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= sh;
          q_r[k+1] <= {q_r[k][QW-2:0], 1'b0};
        end
        dvd_r[k+1] <= {dvd_r[k][QW-2:0], 1'b0};
        den_r[k+1] <= den_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  localparam logic [QW-1:0] HI = QW'((64'd1 << (DATA_WIDTH - 1)) - 1);
  always_comb begin
    if (neg_r[QW]) begin
      quo = (q_r[QW] > HI) ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : DATA_WIDTH'(-q_r[QW]);
    end else begin
      quo = (q_r[QW] > HI) ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : DATA_WIDTH'(q_r[QW]);
    end
  end
endmodule

// ----- sv/rotation_matrix_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Turns a 3x3 rotation matrix into a unit quaternion by the four-branch
// trace method in signed fixed point.
// ----------------------------------------------------------------------------
// The input channel carries one matrix per word, the output channel one
// quaternion with the branch code and a status flag. The cfg channel writes
// the trace threshold; the user must write it only while the block is
// idle; the block itself does not enforce this. The cfg channel is always
// ready. One word is taken every cycle while the receiver does not stall.
// The stages in order are the branch selection register, the square-root
// pipeline, the numerator register, the divider lanes and the output
// register. Three divider lanes run side by side on the numerators, and a
// merging stage places quotients and s/4 in the components of the branch.
// When the receiver stalls the whole pipeline holds and in_tready falls;
// the output register keeps its word. Reset empties the pipeline and sets
// the threshold to one least significant bit.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up
  input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // quat_x, quat_y, quat_z, quat_w, branch_taken, status from the lowest bit up
  output logic [((4*DATA_WIDTH+3+7)/8)*8-1:0] out_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rmq_pkg::EPS_WIDTH-1:0] cfg_data
);
  localparam int W = DATA_WIDTH;
  localparam int AW0 = W + 3;
  localparam int AW = ((AW0 + FRAC_BITS + 1) / 2) * 2;
  localparam int RW = AW / 2;
  localparam int NW = W + 1;
  localparam int QW = NW + FRAC_BITS;
  localparam int OW = ((4*W+3+7)/8)*8;
  localparam int SBW = 2 + 1 + 9 * W;

  logic [rmq_pkg::EPS_WIDTH-1:0] eps_r;
  logic en;
  logic out_valid_r;
  logic [OW-1:0] out_data_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= rmq_pkg::EPS_WIDTH'(rmq_pkg::EPS_RESET);
    end else if (cfg_valid) begin
      eps_r <= cfg_data;
    end
  end

  assign en = !out_valid_r || out_tready;
  assign in_tready = en;

  logic signed [W-1:0] m [9];
  for (genvar i = 0; i < 9; i++) begin : g_unpack
    assign m[i] = in_tdata[i*W +: W];
  end

  // Branch selection
  logic signed [W+1:0] tr;
  logic signed [AW0-1:0] arg_nxt;
  rmq_pkg::branch_t br_nxt;
  localparam logic signed [AW0-1:0] ONE = AW0'(1) << FRAC_BITS;
  always_comb begin
    tr = (W+2)'(m[0]) + (W+2)'(m[4]) + (W+2)'(m[8]);
    if (tr > $signed({2'b00, (W)'(eps_r)})) begin
      br_nxt = rmq_pkg::BR_TRACE;
      arg_nxt = AW0'(tr) + ONE;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      br_nxt = rmq_pkg::BR_X;
      arg_nxt = ONE + AW0'(m[0]) - AW0'(m[4]) - AW0'(m[8]);
    end else if (m[4] > m[8]) begin
      br_nxt = rmq_pkg::BR_Y;
      arg_nxt = ONE + AW0'(m[4]) - AW0'(m[0]) - AW0'(m[8]);
    end else begin
      br_nxt = rmq_pkg::BR_Z;
      arg_nxt = ONE + AW0'(m[8]) - AW0'(m[0]) - AW0'(m[4]);
    end
  end

  logic s0_valid_r;
  logic [AW-1:0] s0_arg_r;
  logic [SBW-1:0] s0_sb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_tvalid;
    end
    if (en) begin
      s0_arg_r <= (arg_nxt <= 0) ? '0 : (AW'(arg_nxt) << FRAC_BITS);
      s0_sb_r <= {br_nxt, (arg_nxt <= 0), in_tdata[9*W-1:0]};
    end
  end

  logic sq_valid;
  logic [RW-1:0] sq_root;
  logic [SBW-1:0] sq_sb;
  rmq_sqrt #(.AW(AW), .SBW(SBW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s0_valid_r), .in_arg(s0_arg_r), .in_sb(s0_sb_r),
    .out_valid(sq_valid), .out_root(sq_root), .out_sb(sq_sb)
  );

  // Numerator forming
  logic signed [W-1:0] sm [9];
  for (genvar i = 0; i < 9; i++) begin : g_sm
    assign sm[i] = sq_sb[i*W +: W];
  end
  logic [1:0] sq_br;
  assign sq_br = sq_sb[SBW-1 -: 2];

  logic signed [NW-1:0] n_nxt [3];
  always_comb begin
    case (sq_br)
      rmq_pkg::BR_TRACE: begin
        n_nxt[0] = NW'(sm[7]) - NW'(sm[5]);
        n_nxt[1] = NW'(sm[2]) - NW'(sm[6]);
        n_nxt[2] = NW'(sm[3]) - NW'(sm[1]);
      end
      rmq_pkg::BR_X: begin
        n_nxt[0] = NW'(sm[1]) + NW'(sm[3]);
        n_nxt[1] = NW'(sm[2]) + NW'(sm[6]);
        n_nxt[2] = NW'(sm[7]) - NW'(sm[5]);
      end
      rmq_pkg::BR_Y: begin
        n_nxt[0] = NW'(sm[1]) + NW'(sm[3]);
        n_nxt[1] = NW'(sm[5]) + NW'(sm[7]);
        n_nxt[2] = NW'(sm[2]) - NW'(sm[6]);
      end
      default: begin
        n_nxt[0] = NW'(sm[2]) + NW'(sm[6]);
        n_nxt[1] = NW'(sm[5]) + NW'(sm[7]);
        n_nxt[2] = NW'(sm[3]) - NW'(sm[1]);
      end
    endcase
  end

  localparam int DL = QW + 1;
  logic signed [NW-1:0] n_r [3];
  logic [RW:0] s_r;
  logic d_valid_r [DL];
  logic [1:0] d_br_r [DL];
  logic d_err_r [DL];
  logic [RW-1:0] d_q_r [DL];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DL; k++) d_valid_r[k] <= 1'b0;
    end else if (en) begin
      d_valid_r[0] <= sq_valid;
      for (int k = 1; k < DL; k++) d_valid_r[k] <= d_valid_r[k-1];
    end
    if (en) begin
      n_r <= n_nxt;
      s_r <= {sq_root, 1'b0};
      d_br_r[0] <= sq_br;
      d_err_r[0] <= sq_sb[SBW-3];
      d_q_r[0] <= sq_root >> 1;
      for (int k = 1; k < DL; k++) begin
        d_br_r[k] <= d_br_r[k-1];
        d_err_r[k] <= d_err_r[k-1];
        d_q_r[k] <= d_q_r[k-1];
      end
    end
  end

  logic signed [W-1:0] quo [3];
  for (genvar l = 0; l < 3; l++) begin : g_lane
    rmq_div_lane #(.NW(NW), .DW(RW+1), .QW(QW), .FRAC_BITS(FRAC_BITS),
                   .DATA_WIDTH(W)) u_lane (
      .clk(clk), .en(en), .num(n_r[l]),
      .den((s_r == '0) ? (RW+1)'(1) : s_r), .quo(quo[l])
    );
  end

  // Merging stage
  logic [W-1:0] qt;
  logic [W-1:0] qx, qy, qz, qw;
  localparam logic [RW-1:0] HIQ = RW'((64'd1 << (W - 1)) - 1);
  always_comb begin
    qt = (d_q_r[DL-1] > HIQ) ? W'(HIQ) : W'(d_q_r[DL-1]);
    case (d_br_r[DL-1])
      rmq_pkg::BR_TRACE: begin
        qx = quo[0]; qy = quo[1]; qz = quo[2]; qw = qt;
      end
      rmq_pkg::BR_X: begin
        qx = qt; qy = quo[0]; qz = quo[1]; qw = quo[2];
      end
      rmq_pkg::BR_Y: begin
        qx = quo[0]; qy = qt; qz = quo[1]; qw = quo[2];
      end
      default: begin
        qx = quo[0]; qy = quo[1]; qz = qt; qw = quo[2];
      end
    endcase
    if (d_err_r[DL-1] == rmq_pkg::ST_ARG_ERR) begin
      qx = '0; qy = '0; qz = '0; qw = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid_r[DL-1];
    end
    if (en) begin
      out_data_r <= OW'({d_err_r[DL-1], d_br_r[DL-1], qw, qz, qy, qx});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
endmodule

// ----- sv/rmq_checker.sv -----
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
module rmq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [71:0] out_tdata,
  input logic       cfg_ready
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[66] |-> out_tdata[63:0] == 64'd0)
    else $error("error word carries non-zero quaternion");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
  a_cfg: assert property (@(posedge clk) cfg_ready)
    else $error("configuration port not ready");
endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .cfg_ready(cfg_ready)
);
